// ----- rtl/core/lnlm_pkg.sv -----
// Shared types and constants for the linked node list manager.
// Depends on nothing; every module of the block imports it.
package lnlm_pkg;

  localparam int NODES  = 64;
  localparam int IDX_W  = $clog2(NODES);
  localparam int LINK_W = IDX_W + 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  // Link value that stands for "no node"
  localparam link_t NONE = LINK_W'(NODES);

  typedef enum logic [1:0] {
    MODE_ALLOC     = 2'd0,
    MODE_FREE      = 2'd1,
    MODE_REVERSE   = 2'd2,
    MODE_READ_NEXT = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  at_front;
    idx_t  node;
  } req_t;

  typedef struct packed {
    link_t result_node;
    logic  ok;
    link_t list_head;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_A_POP,
    ST_A_WALK,
    ST_A_FIN,
    ST_F_HEAD,
    ST_F_WALK,
    ST_F_GETX,
    ST_F_PUSH,
    ST_R_LOOP,
    ST_RN_DONE,
    ST_DONE
  } state_t;

  // Datapath micro-operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_ALLOC_START,
    OP_ALLOC_FRONT,
    OP_ALLOC_TAIL_START,
    OP_WALK_START,
    OP_WALK,
    OP_ALLOC_LINK,
    OP_ALLOC_END,
    OP_READ_NODE,
    OP_FREE_HEAD,
    OP_FREE_SPLICE,
    OP_FREE_PUSH,
    OP_REV_START,
    OP_REV_STEP,
    OP_READ_NEXT,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    mode_t mode;
    logic  at_front;
    logic  free_empty;
    logic  used_empty;
    logic  head_is_node;
    logic  link_valid;
    logic  link_is_node;
    logic  out_busy;
  } status_t;

endpackage

// ----- rtl/core/lnlm_datapath.sv -----
// Datapath: link memory with reset-valid bits, list heads, walk pointer and
// result register. Executes one micro-operation per cycle; uses lnlm_pkg.
module lnlm_datapath import lnlm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  dp_op_t  op,
  input  req_t    req,
  output status_t status,
  input  logic    rsp_stall,
  output logic    rsp_valid,
  output rsp_t    rsp
);

  link_t            mem [NODES];
  logic [NODES-1:0] written;
  link_t            rd_data_q;
  idx_t             rd_addr_q;
  logic             rd_written_q;
  idx_t             rd_addr;
  logic             wr_en;
  idx_t             wr_addr;
  link_t            wr_data;
  link_t            link_now;

  req_t  cur_req;
  idx_t  alloc_node;
  idx_t  walk_ptr;
  link_t used_head;
  link_t free_head;
  link_t res_node;
  logic  res_ok;

  // Link of the node read last cycle; an unwritten entry holds its reset link
  assign link_now = rd_written_q ? rd_data_q : LINK_W'(rd_addr_q) + LINK_W'(1);

  // Select read address
  always_comb begin
    case (op)
      OP_ALLOC_START:                              rd_addr = free_head[IDX_W-1:0];
      OP_ALLOC_TAIL_START, OP_WALK_START, OP_REV_START: rd_addr = used_head[IDX_W-1:0];
      OP_WALK, OP_REV_STEP:                        rd_addr = link_now[IDX_W-1:0];
      default:                                     rd_addr = cur_req.node;
    endcase
  end

  // Select write address and data
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = walk_ptr;
    wr_data = used_head;
    case (op)
      OP_ALLOC_FRONT: begin
        wr_addr = alloc_node;
        wr_data = used_head;
      end
      OP_ALLOC_LINK: begin
        wr_addr = walk_ptr;
        wr_data = LINK_W'(alloc_node);
      end
      OP_ALLOC_END: begin
        wr_addr = alloc_node;
        wr_data = NONE;
      end
      OP_FREE_HEAD, OP_FREE_PUSH: begin
        wr_addr = cur_req.node;
        wr_data = free_head;
      end
      OP_FREE_SPLICE: begin
        wr_addr = walk_ptr;
        wr_data = link_now;
      end
      OP_REV_STEP: begin
        wr_addr = walk_ptr;
        wr_data = used_head;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Link memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q    <= mem[rd_addr];
    rd_addr_q    <= rd_addr;
    rd_written_q <= written[rd_addr];
  end

  // Control state: heads, valid bits, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      used_head <= NONE;
      free_head <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      case (op)
        OP_ALLOC_FRONT: begin
          used_head <= LINK_W'(alloc_node);
          free_head <= link_now;
        end
        OP_ALLOC_TAIL_START: free_head <= link_now;
        OP_FREE_HEAD: begin
          used_head <= link_now;
          free_head <= LINK_W'(cur_req.node);
        end
        OP_FREE_PUSH: free_head <= LINK_W'(cur_req.node);
        OP_REV_START: used_head <= NONE;
        OP_REV_STEP:  used_head <= LINK_W'(walk_ptr);
        default: ;
      endcase
      if (op == OP_OUT) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        cur_req  <= req;
        res_node <= NONE;
        res_ok   <= 1'b0;
      end
      OP_ALLOC_START: alloc_node <= free_head[IDX_W-1:0];
      OP_ALLOC_FRONT, OP_ALLOC_END: begin
        res_node <= LINK_W'(alloc_node);
        res_ok   <= 1'b1;
      end
      OP_ALLOC_TAIL_START, OP_WALK_START, OP_REV_START: walk_ptr <= used_head[IDX_W-1:0];
      OP_WALK, OP_REV_STEP: walk_ptr <= link_now[IDX_W-1:0];
      OP_READ_NEXT: begin
        res_node <= link_now;
        res_ok   <= (link_now != NONE);
      end
      OP_OUT: begin
        rsp.result_node <= res_node;
        rsp.ok          <= res_ok;
        rsp.list_head   <= used_head;
      end
      default: ;
    endcase
  end

  // Status to the controller
  always_comb begin
    status.mode         = cur_req.mode;
    status.at_front     = cur_req.at_front;
    status.free_empty   = (free_head == NONE);
    status.used_empty   = (used_head == NONE);
    status.head_is_node = (used_head == LINK_W'(cur_req.node));
    status.link_valid   = (link_now != NONE);
    status.link_is_node = (link_now == LINK_W'(cur_req.node));
    status.out_busy     = rsp_valid && rsp_stall;
  end

endmodule

// ----- rtl/core/lnlm_ctrl.sv -----
// Controller: sequences allocate, free, reverse and read-next, walking the list where needed.
// Drives datapath micro-operations from its status; uses lnlm_pkg.
module lnlm_ctrl import lnlm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  status_t status,
  output dp_op_t  op
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and micro-operation
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    req_stall  = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op         = OP_ACCEPT;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.mode)
          MODE_ALLOC: begin
            if (status.free_empty) begin
              state_next = ST_DONE;
            end else begin
              op         = OP_ALLOC_START;
              state_next = ST_A_POP;
            end
          end
          MODE_FREE: begin
            if (status.head_is_node) begin
              op         = OP_READ_NODE;
              state_next = ST_F_HEAD;
            end else if (status.used_empty) begin
              state_next = ST_DONE;
            end else begin
              op         = OP_WALK_START;
              state_next = ST_F_WALK;
            end
          end
          MODE_REVERSE: begin
            if (status.used_empty) begin
              state_next = ST_DONE;
            end else begin
              op         = OP_REV_START;
              state_next = ST_R_LOOP;
            end
          end
          default: begin
            op         = OP_READ_NODE;
            state_next = ST_RN_DONE;
          end
        endcase
      end
      ST_A_POP: begin
        if (status.at_front || status.used_empty) begin
          op         = OP_ALLOC_FRONT;
          state_next = ST_DONE;
        end else begin
          op         = OP_ALLOC_TAIL_START;
          state_next = ST_A_WALK;
        end
      end
      // Advance to the tail, then link the new node behind it
      ST_A_WALK: begin
        if (status.link_valid) begin
          op = OP_WALK;
        end else begin
          op         = OP_ALLOC_LINK;
          state_next = ST_A_FIN;
        end
      end
      ST_A_FIN: begin
        op         = OP_ALLOC_END;
        state_next = ST_DONE;
      end
      ST_F_HEAD: begin
        op         = OP_FREE_HEAD;
        state_next = ST_DONE;
      end
      // Search for the predecessor; leave the lists unchanged if the node is absent
      ST_F_WALK: begin
        if (status.link_is_node) begin
          op         = OP_READ_NODE;
          state_next = ST_F_GETX;
        end else if (status.link_valid) begin
          op = OP_WALK;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_F_GETX: begin
        op         = OP_FREE_SPLICE;
        state_next = ST_F_PUSH;
      end
      ST_F_PUSH: begin
        op         = OP_FREE_PUSH;
        state_next = ST_DONE;
      end
      ST_R_LOOP: begin
        op = OP_REV_STEP;
        if (!status.link_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_RN_DONE: begin
        op         = OP_READ_NEXT;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          op         = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/linked_node_list_manager_unit.sv -----
// Top level of the linked node list manager: controller plus datapath.
// Depends on lnlm_pkg, lnlm_ctrl and lnlm_datapath.
//
// Manages a pool of NODES nodes threaded into a free list and an ordered
// in-use list in a single link memory with one read and one write port.
// One item is worked at a time; the next is accepted once the current one
// has moved to the output register, even while that result still waits.
// Read-next, front allocate and free of the head node run without a walk;
// allocate from an empty pool, and free or reverse on an empty list, go
// straight to the result. Tail allocate, free of a later node and reverse walk
// the in-use list one link per cycle through the memory read port. Entries
// never written read as their reset link through per-entry valid bits, so
// no clearing pass follows reset.
module linked_node_list_manager_unit import lnlm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  status_t status;
  dp_op_t  op;

  lnlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .op        (op)
  );

  lnlm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .req       (req),
    .status    (status),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // ok is set exactly when a real node is reported
  a_ok_matches_node: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.ok == (rsp.result_node != NONE)))
    else $error("ok flag disagrees with result node");

  // Reported links never exceed the none code
  a_links_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.list_head <= NONE && rsp.result_node <= NONE))
    else $error("reported link out of range");

  // An accepted item holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("item accepted while previous item in progress");

  // Loading a result always presents it
  a_result_presented: assert property (@(posedge clk) disable iff (rst)
    (op == OP_OUT) |=> rsp_valid)
    else $error("result loaded but not presented");
`endif

endmodule

// ----- verif/linked_node_list_manager_unit_test.sv -----
// Self-checking bench for linked_node_list_manager_unit: walks a table of
// directed items, then random fill/churn/drain phases, checked by a local list model.
// Depends on lnlm_pkg and the block's RTL only.
`timescale 1ns / 100ps

module linked_node_list_manager_unit_test;
  import lnlm_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int RAND_ITEMS  = 1928;
  localparam int QUIET_FROM  = 1750;
  localparam int DRAIN_WAIT  = 80;
  localparam int MAX_PRINTS  = 40;

  // One row of the directed table; when typed is set, e is the result to see
  typedef struct packed {
    req_t  r;
    logic  typed;
    rsp_t  e;
  } vec_t;

  localparam int DIR_ROWS = 22;
  localparam vec_t DIR_TAB [DIR_ROWS] = '{
    // fresh pool: successor of the first node, none past the last, empty walks
    '{'{MODE_READ_NEXT, 1'b0, 6'd0},  1'b1, '{7'd1, 1'b1, NONE}},
    '{'{MODE_READ_NEXT, 1'b1, 6'd63}, 1'b1, '{NONE, 1'b0, NONE}},
    '{'{MODE_REVERSE,   1'b0, 6'd0},  1'b1, '{NONE, 1'b0, NONE}},
    // free of a node never handed out
    '{'{MODE_FREE,      1'b0, 6'd5},  1'b1, '{NONE, 1'b0, NONE}},
    // tail allocate into an empty list, then front allocate
    '{'{MODE_ALLOC,     1'b0, 6'd63}, 1'b1, '{7'd0, 1'b1, 7'd0}},
    '{'{MODE_ALLOC,     1'b1, 6'd0},  1'b1, '{7'd1, 1'b1, 7'd1}},
    '{'{MODE_ALLOC,     1'b0, 6'd0},  1'b0, '0},
    '{'{MODE_ALLOC,     1'b0, 6'd21}, 1'b0, '0},
    '{'{MODE_READ_NEXT, 1'b0, 6'd0},  1'b0, '0},
    // successor of a node still on the free list
    '{'{MODE_READ_NEXT, 1'b1, 6'd4},  1'b0, '0},
    '{'{MODE_REVERSE,   1'b1, 6'd42}, 1'b0, '0},
    // unlink from the middle, then the same node again
    '{'{MODE_FREE,      1'b0, 6'd2},  1'b0, '0},
    '{'{MODE_FREE,      1'b1, 6'd2},  1'b0, '0},
    '{'{MODE_FREE,      1'b0, 6'd3},  1'b0, '0},
    '{'{MODE_READ_NEXT, 1'b0, 6'd2},  1'b0, '0},
    '{'{MODE_ALLOC,     1'b1, 6'd63}, 1'b0, '0},
    '{'{MODE_FREE,      1'b0, 6'd1},  1'b0, '0},
    '{'{MODE_ALLOC,     1'b0, 6'd0},  1'b0, '0},
    '{'{MODE_READ_NEXT, 1'b0, 6'd1},  1'b0, '0},
    '{'{MODE_REVERSE,   1'b0, 6'd63}, 1'b0, '0},
    '{'{MODE_FREE,      1'b1, 6'd63}, 1'b0, '0},
    '{'{MODE_ALLOC,     1'b1, 6'd63}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Local copy of the pool links and list heads
  link_t nl [NODES];
  link_t used_hd;
  link_t free_hd;

  rsp_t due_rsp_q [$];
  logic pend_typed;
  rsp_t pend_rsp;
  logic idle_on = 1'b0;
  int   stall_left = 0;
  int   n_accepted = 0;
  int   n_checked = 0;
  int   n_errors = 0;
  int   n_pool_dry = 0;

  linked_node_list_manager_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic bit is_node(link_t v);
    return v < NODES;
  endfunction

  function automatic void pool_reset();
    for (int i = 0; i < NODES; i++) begin
      nl[i] = link_t'(i + 1);
    end
    nl[NODES-1] = NONE;
    used_hd = NONE;
    free_hd = '0;
  endfunction

  // Pop the free head; insert at front or walk to the tail and append
  function automatic link_t pool_alloc(logic front);
    link_t n;
    link_t p;
    n = free_hd;
    if (!is_node(n)) return NONE;
    free_hd = nl[n];
    if (front || !is_node(used_hd)) begin
      nl[n] = used_hd;
      used_hd = n;
    end else begin
      p = used_hd;
      for (int s = 0; s < NODES && is_node(nl[p]); s++) p = nl[p];
      nl[p] = n;
      nl[n] = NONE;
    end
    return n;
  endfunction

  // Unlink a node from the in-use list and push it on the free list
  function automatic void pool_free(idx_t n);
    link_t p;
    link_t nn;
    nn = link_t'(n);
    if (used_hd == nn) begin
      used_hd = nl[n];
    end else begin
      p = used_hd;
      for (int s = 0; s < NODES && is_node(p) && nl[p] != nn; s++) p = nl[p];
      if (!is_node(p)) return;
      if (nl[p] != nn) return;
      nl[p] = nl[n];
    end
    nl[n] = free_hd;
    free_hd = nn;
  endfunction

  function automatic void pool_reverse();
    link_t cur;
    link_t nxt;
    cur = used_hd;
    used_hd = NONE;
    for (int s = 0; s < NODES && is_node(cur); s++) begin
      nxt = nl[cur];
      nl[cur] = used_hd;
      used_hd = cur;
      cur = nxt;
    end
  endfunction

  // Apply one item to the local lists and return the result it gives
  function automatic rsp_t list_step(req_t r);
    rsp_t o;
    o.result_node = NONE;
    o.ok = 1'b0;
    case (r.mode)
      MODE_ALLOC: begin
        o.result_node = pool_alloc(r.at_front);
        o.ok = is_node(o.result_node);
      end
      MODE_FREE: pool_free(r.node);
      MODE_REVERSE: pool_reverse();
      default: begin
        o.result_node = nl[r.node];
        o.ok = is_node(o.result_node);
      end
    endcase
    o.list_head = used_hd;
    return o;
  endfunction

  function automatic int used_len();
    link_t p;
    int n;
    p = used_hd;
    n = 0;
    while (n < NODES && is_node(p)) begin
      p = nl[p];
      n++;
    end
    return n;
  endfunction

  // Random member of the in-use list, or any index if it is empty
  function automatic idx_t pick_used();
    link_t p;
    int k;
    int len;
    len = used_len();
    if (len == 0) return idx_t'($urandom_range(0, NODES - 1));
    k = $urandom_range(0, len - 1);
    p = used_hd;
    repeat (k) p = nl[p];
    return idx_t'(p);
  endfunction

  function automatic req_t mk_req(mode_t m, logic f, idx_t n);
    req_t r;
    r.mode = m;
    r.at_front = f;
    r.node = n;
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [6:0] got, logic [6:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("%0t ERROR result %0d %s: got %0d want %0d", $realtime, n_checked, what, got,
               want);
  endtask

  task automatic check_rsp(rsp_t got);
    rsp_t want;
    if (due_rsp_q.size() == 0) begin
      note_mismatch("unexpected", got.result_node, NONE);
      return;
    end
    want = due_rsp_q.pop_front();
    if (got.result_node !== want.result_node)
      note_mismatch("result_node", got.result_node, want.result_node);
    if (got.ok !== want.ok) note_mismatch("ok", 7'(got.ok), 7'(want.ok));
    if (got.list_head !== want.list_head)
      note_mismatch("list_head", got.list_head, want.list_head);
    n_checked++;
  endtask

  // Check finished results, then predict for each accepted item
  always @(posedge clk) begin
    rsp_t p;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) check_rsp(rsp);
      if (req_valid && !req_stall) begin
        p = list_step(req);
        if (req.mode == MODE_ALLOC && !p.ok) n_pool_dry++;
        due_rsp_q.push_back(pend_typed ? pend_rsp : p);
        n_accepted++;
      end
    end
  end

  // Hold off results in random bursts
  always @(negedge clk) begin
    if (rst || !idle_on) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      rsp_stall <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Offer one item from a falling edge and return at the falling edge after accept
  task automatic send_item(req_t r, logic typed, rsp_t e);
    int seen;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    seen = n_accepted;
    pend_typed = typed;
    pend_rsp = e;
    req_valid <= 1'b1;
    req <= r;
    do @(negedge clk); while (n_accepted == seen);
  endtask

  initial begin
    int n_rand;
    int kind;
    int w;
    int len;
    idx_t n;
    req_t r;
    pool_reset();
    pend_typed = 1'b0;
    pend_rsp = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) send_item(DIR_TAB[i].r, DIR_TAB[i].typed, DIR_TAB[i].e);

    // Random phases: fill the pool dry, churn, or drain the in-use list
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      if (n_rand >= QUIET_FROM) idle_on <= 1'b0;
      else idle_on <= ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      // draining an empty list sends nothing; churn instead
      if (kind >= 75 && !is_node(used_hd)) kind = 50;
      if (kind < 25) begin
        while (is_node(free_hd)) begin
          if ($urandom_range(0, 7) == 0)
            r = mk_req(MODE_READ_NEXT, 1'($urandom), idx_t'($urandom));
          else
            r = mk_req(MODE_ALLOC, 1'($urandom), idx_t'($urandom));
          send_item(r, 1'b0, '0);
          n_rand++;
        end
        repeat ($urandom_range(1, 2)) begin
          send_item(mk_req(MODE_ALLOC, 1'($urandom), idx_t'($urandom)), 1'b0, '0);
          n_rand++;
        end
      end else if (kind < 75) begin
        len = $urandom_range(40, 120);
        repeat (len) begin
          w = $urandom_range(0, 99);
          if (w < 35 || (w < 65 && !is_node(used_hd)))
            r = mk_req(MODE_ALLOC, 1'($urandom), idx_t'($urandom));
          else if (w < 65)
            r = mk_req(MODE_FREE, 1'($urandom), pick_used());
          else if (w < 70)
            r = mk_req(MODE_FREE, 1'($urandom), idx_t'($urandom));
          else if (w < 80)
            r = mk_req(MODE_REVERSE, 1'($urandom), idx_t'($urandom));
          else if (w < 90)
            r = mk_req(MODE_READ_NEXT, 1'($urandom), pick_used());
          else
            r = mk_req(MODE_READ_NEXT, 1'($urandom), idx_t'($urandom));
          n_rand++;
          send_item(r, 1'b0, '0);
        end
      end else begin
        while (is_node(used_hd)) begin
          if ($urandom_range(0, 9) == 0) begin
            r = mk_req(MODE_REVERSE, 1'($urandom), idx_t'($urandom));
          end else begin
            n = pick_used();
            r = mk_req(MODE_FREE, 1'($urandom), n);
          end
          send_item(r, 1'b0, '0);
          n_rand++;
        end
      end
    end
    req_valid <= 1'b0;
    idle_on <= 1'b0;

    // Drain outstanding results, then watch for strays
    for (w = 0; w < 20000 && due_rsp_q.size() != 0; w++) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (due_rsp_q.size() != 0) begin
      note_mismatch("missing", 7'(due_rsp_q.size()), 7'd0);
    end

    $display("Accepted %0d items (%0d directed), checked %0d results.", n_accepted, DIR_ROWS,
             n_checked);
    $display("Allocations refused on an empty pool: %0d.", n_pool_dry);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
